FILE: rtl/rit_pkg.sv
// Shared widths, register codes, reset values and word types for the
// reprojection inlier test. No dependencies; every other rtl file uses it.
package rit_pkg;

    // input and output field widths
    localparam int IDX_W    = 16;
    localparam int PT_W     = 24;
    localparam int PIX_W    = 16;
    localparam int ERR_W    = 32;
    localparam int IN_W     = IDX_W + 3 * PT_W + 2 * PIX_W;
    localparam int OUT_W    = IDX_W + ERR_W;
    localparam int USER_W   = 2;

    // pose and intrinsics
    localparam int ROT_W    = 16;
    localparam int ROW_W    = 3 * ROT_W;
    localparam int TR_W     = 21;
    localparam int TRV_W    = 3 * TR_W;
    localparam int TR_SHIFT = 14;
    localparam int FOC_W    = 16;
    localparam int FPAIR_W  = 2 * FOC_W;

    // datapath widths
    localparam int PROD_W   = ROT_W + PT_W;
    localparam int CAM_W    = PROD_W + 2;
    localparam int MAG_W    = CAM_W - 1;
    localparam int MAG_LO_W = 21;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int PPL_W    = FOC_W + MAG_LO_W;
    localparam int PPH_W    = FOC_W + MAG_HI_W;
    localparam int NUM_W    = FOC_W + MAG_W + 1;
    localparam int DEN_W    = MAG_W + 1;
    localparam int Q_W      = 18;
    localparam int REM_W    = DEN_W + Q_W;
    localparam int OFF_W    = Q_W + 2;
    localparam int DIFF_W   = OFF_W + 1;
    localparam int SQ_W     = 2 * PIX_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd6;

    localparam logic [ROW_W-1:0]   ROT0_RST      = 48'd16384;
    localparam logic [ROW_W-1:0]   ROT1_RST      = 48'd1073741824;
    localparam logic [ROW_W-1:0]   ROT2_RST      = 48'd70368744177664;
    localparam logic [TRV_W-1:0]   TRANS_RST     = 63'd0;
    localparam logic [FPAIR_W-1:0] FOCAL_RST     = 32'd524296000;
    localparam logic [FPAIR_W-1:0] PRINCIPAL_RST = 32'd251663360;
    localparam logic [ERR_W-1:0]   LIMIT_RST     = 32'd1024;

    // fields that ride alongside the arithmetic
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } side_t;

    // one restoring division step: partial remainder, doubled depth, quotient so far
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quo;
    } div_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             inlier;
        logic             behind;
        logic [ERR_W-1:0] err;
    } result_t;

endpackage

FILE: rtl/rit_transform.sv
// Rigid transform of the world point into the camera frame: R * p + t.
// Two register stages (products, then sums). Uses rit_pkg.
module rit_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  rit_pkg::side_t                       in_side,
    input  logic signed [rit_pkg::PT_W-1:0]      point_x,
    input  logic signed [rit_pkg::PT_W-1:0]      point_y,
    input  logic signed [rit_pkg::PT_W-1:0]      point_z,
    input  logic [rit_pkg::ROW_W-1:0]            rot0,
    input  logic [rit_pkg::ROW_W-1:0]            rot1,
    input  logic [rit_pkg::ROW_W-1:0]            rot2,
    input  logic [rit_pkg::TRV_W-1:0]            trans,
    output logic                                 out_valid,
    output rit_pkg::side_t                       out_side,
    output logic signed [rit_pkg::CAM_W-1:0]     cam_x,
    output logic signed [rit_pkg::CAM_W-1:0]     cam_y,
    output logic signed [rit_pkg::CAM_W-1:0]     cam_z
);

    logic [1:0]                             vld_reg;
    rit_pkg::side_t                         side_a_reg;
    rit_pkg::side_t                         side_b_reg;
    logic signed [rit_pkg::PT_W-1:0]        pt [3];
    logic [rit_pkg::ROW_W-1:0]              rot [3];
    logic signed [rit_pkg::PROD_W-1:0]      prod_reg [3][3];
    logic signed [rit_pkg::CAM_W-1:0]       tr_reg [3];
    logic signed [rit_pkg::CAM_W-1:0]       cam_reg [3];

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign rot[0] = rot0;
    assign rot[1] = rot1;
    assign rot[2] = rot2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= $signed(rot[r][c*rit_pkg::ROT_W +: rit_pkg::ROT_W])
                                      * pt[c];
                end
                // translation to the product scale
                tr_reg[r] <= $signed(rit_pkg::CAM_W'(
                                 $signed(trans[r*rit_pkg::TR_W +: rit_pkg::TR_W])))
                             <<< rit_pkg::TR_SHIFT;
            end
            for (int r = 0; r < 3; r++)
            begin
                cam_reg[r] <= tr_reg[r]
                              + rit_pkg::CAM_W'(prod_reg[r][0])
                              + rit_pkg::CAM_W'(prod_reg[r][1])
                              + rit_pkg::CAM_W'(prod_reg[r][2]);
            end
            side_a_reg <= in_side;
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_side  = side_b_reg;
    assign cam_x     = cam_reg[0];
    assign cam_y     = cam_reg[1];
    assign cam_z     = cam_reg[2];

endmodule

FILE: rtl/rit_div_step.sv
// One registered step of the restoring divider: compare, subtract, shift.
// Uses rit_pkg::div_t.
module rit_div_step (
    input  logic           clk,
    input  logic           en,
    input  rit_pkg::div_t  din,
    output rit_pkg::div_t  dout
);

    rit_pkg::div_t              dout_reg;
    logic [rit_pkg::REM_W-1:0]  trial;
    logic [rit_pkg::REM_W-1:0]  rem_sub;
    logic                       ge;

    always_comb
    begin
        trial   = rit_pkg::REM_W'({din.den, {(rit_pkg::Q_W-1){1'b0}}});
        ge      = din.rem >= trial;
        rem_sub = ge ? din.rem - trial : din.rem;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg.rem <= {rem_sub[rit_pkg::REM_W-2:0], 1'b0};
            dout_reg.den <= din.den;
            dout_reg.quo <= {din.quo[rit_pkg::Q_W-2:0], ge};
        end
    end

    assign dout = dout_reg;

endmodule

FILE: rtl/rit_project.sv
// Pinhole projection offsets f*X/Z and f*Y/Z rounded to nearest, for both axes.
// Magnitude, split multiply, numerator build, range check, then one quotient
// bit per stage through rit_div_step. Uses rit_pkg.
module rit_project (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  rit_pkg::side_t                       in_side,
    input  logic signed [rit_pkg::CAM_W-1:0]     cam_x,
    input  logic signed [rit_pkg::CAM_W-1:0]     cam_y,
    input  logic signed [rit_pkg::CAM_W-1:0]     cam_z,
    input  logic [rit_pkg::FPAIR_W-1:0]          focal,
    output logic                                 out_valid,
    output rit_pkg::side_t                       out_side,
    output logic                                 out_behind,
    output logic signed [rit_pkg::OFF_W-1:0]     off_x,
    output logic signed [rit_pkg::OFF_W-1:0]     off_y
);

    localparam int LAT = rit_pkg::Q_W + 5;

    typedef struct packed {
        rit_pkg::side_t side;
        logic           behind;
        logic [1:0]     neg;
        logic [1:0]     ovf;
    } tag_t;

    logic [LAT-1:0]                         vld_reg;
    tag_t                                   tag_reg [LAT-1];
    tag_t                                   tag_first;
    tag_t                                   tag_p4;
    logic                                   behind_in;
    logic signed [rit_pkg::CAM_W-1:0]       cam [2];
    logic [rit_pkg::FOC_W-1:0]              foc [2];
    logic [rit_pkg::MAG_W-1:0]              mag1_reg [2];
    logic [rit_pkg::MAG_W-1:0]              dep1_reg;
    logic [rit_pkg::MAG_W-1:0]              dep2_reg;
    logic [rit_pkg::PPL_W-1:0]              pl2_reg [2];
    logic [rit_pkg::PPH_W-1:0]              ph2_reg [2];
    logic [rit_pkg::NUM_W-1:0]              num3_reg [2];
    logic [rit_pkg::DEN_W-1:0]              den3_reg;
    logic [1:0]                             ovf;
    rit_pkg::div_t                          div4_reg [2];
    rit_pkg::div_t                          chain [2][rit_pkg::Q_W+1];
    logic signed [rit_pkg::OFF_W-1:0]       qmag [2];
    logic signed [rit_pkg::OFF_W-1:0]       off_next [2];
    logic signed [rit_pkg::OFF_W-1:0]       off_reg [2];
    rit_pkg::side_t                         side_reg;
    logic                                   behind_reg;

    assign cam[0] = cam_x;
    assign cam[1] = cam_y;
    assign foc[0] = focal[rit_pkg::FOC_W-1:0];
    assign foc[1] = focal[rit_pkg::FPAIR_W-1:rit_pkg::FOC_W];

    assign behind_in = cam_z[rit_pkg::CAM_W-1] || (cam_z == '0);

    always_comb
    begin
        tag_first.side   = in_side;
        tag_first.behind = behind_in;
        tag_first.neg    = {cam_y[rit_pkg::CAM_W-1], cam_x[rit_pkg::CAM_W-1]};
        tag_first.ovf    = '0;
    end

    // quotient would not fit in Q_W bits: the pixel error saturates anyway
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ovf[l] = rit_pkg::REM_W'(num3_reg[l]) >= {den3_reg, {rit_pkg::Q_W{1'b0}}};
        end
        tag_p4     = tag_reg[2];
        tag_p4.ovf = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_first;
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= tag_reg[1];
            tag_reg[3] <= tag_p4;
            for (int s = 4; s < LAT - 1; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end

            for (int l = 0; l < 2; l++)
            begin
                mag1_reg[l] <= cam[l][rit_pkg::CAM_W-1] ? rit_pkg::MAG_W'(-cam[l])
                                                         : rit_pkg::MAG_W'(cam[l]);
                pl2_reg[l]  <= rit_pkg::PPL_W'(foc[l])
                               * rit_pkg::PPL_W'(mag1_reg[l][rit_pkg::MAG_LO_W-1:0]);
                ph2_reg[l]  <= rit_pkg::PPH_W'(foc[l])
                               * rit_pkg::PPH_W'(mag1_reg[l][rit_pkg::MAG_W-1:rit_pkg::MAG_LO_W]);
                // 2*f*|c| + z, divided later by 2*z, rounds half away from zero
                num3_reg[l] <= (rit_pkg::NUM_W'(ph2_reg[l]) << (rit_pkg::MAG_LO_W + 1))
                               + (rit_pkg::NUM_W'(pl2_reg[l]) << 1)
                               + rit_pkg::NUM_W'(dep2_reg);
                div4_reg[l] <= '{rem: rit_pkg::REM_W'(num3_reg[l]),
                                 den: den3_reg,
                                 quo: '0};
                off_reg[l]  <= off_next[l];
            end

            // no divide for a point behind the camera: keep the divisor nonzero
            dep1_reg   <= behind_in ? rit_pkg::MAG_W'(1) : cam_z[rit_pkg::MAG_W-1:0];
            dep2_reg   <= dep1_reg;
            den3_reg   <= {dep2_reg, 1'b0};
            side_reg   <= tag_reg[LAT-2].side;
            behind_reg <= tag_reg[LAT-2].behind;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        assign chain[l][0] = div4_reg[l];
        for (genvar s = 0; s < rit_pkg::Q_W; s++)
        begin : g_step
            rit_div_step u_step (
                .clk  (clk),
                .en   (en),
                .din  (chain[l][s]),
                .dout (chain[l][s+1])
            );
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            qmag[l] = tag_reg[LAT-2].ovf[l] ? (rit_pkg::OFF_W'(1) << rit_pkg::Q_W)
                                            : rit_pkg::OFF_W'(chain[l][rit_pkg::Q_W].quo);
            off_next[l] = tag_reg[LAT-2].neg[l] ? -qmag[l] : qmag[l];
        end
    end

    assign out_valid  = vld_reg[LAT-1];
    assign out_side   = side_reg;
    assign out_behind = behind_reg;
    assign off_x      = off_reg[0];
    assign off_y      = off_reg[1];

endmodule

FILE: rtl/rit_error.sv
// Pixel residuals, squared error with saturation and the threshold compare.
// Four register stages. Uses rit_pkg.
module rit_error (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  rit_pkg::side_t                       in_side,
    input  logic                                 in_behind,
    input  logic signed [rit_pkg::OFF_W-1:0]     off_x,
    input  logic signed [rit_pkg::OFF_W-1:0]     off_y,
    input  logic [rit_pkg::FPAIR_W-1:0]          principal,
    input  logic [rit_pkg::ERR_W-1:0]            limit,
    output logic                                 out_valid,
    output rit_pkg::result_t                     result
);

    logic [3:0]                             vld_reg;
    logic signed [rit_pkg::DIFF_W-1:0]      pix [2];
    logic signed [rit_pkg::DIFF_W-1:0]      cen [2];
    logic signed [rit_pkg::DIFF_W-1:0]      off [2];
    logic signed [rit_pkg::DIFF_W-1:0]      diff1_reg [2];
    logic [rit_pkg::DIFF_W-1:0]             adiff [2];
    logic [rit_pkg::PIX_W-1:0]              mag2_reg [2];
    logic [1:0]                             big2_reg;
    logic [1:0]                             big3_reg;
    logic [rit_pkg::SQ_W-1:0]               sq3_reg [2];
    logic [rit_pkg::SQ_W:0]                 sum;
    logic                                   over;
    logic [rit_pkg::ERR_W-1:0]              err;
    logic [2:0]                             behind_reg;
    logic [rit_pkg::IDX_W-1:0]              index_reg [3];
    rit_pkg::result_t                       result_reg;

    assign pix[0] = rit_pkg::DIFF_W'(in_side.u);
    assign pix[1] = rit_pkg::DIFF_W'(in_side.v);
    assign cen[0] = rit_pkg::DIFF_W'(principal[rit_pkg::PIX_W-1:0]);
    assign cen[1] = rit_pkg::DIFF_W'(principal[rit_pkg::FPAIR_W-1:rit_pkg::PIX_W]);
    assign off[0] = rit_pkg::DIFF_W'(off_x);
    assign off[1] = rit_pkg::DIFF_W'(off_y);

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            adiff[l] = diff1_reg[l][rit_pkg::DIFF_W-1] ? -diff1_reg[l] : diff1_reg[l];
        end
        sum  = {1'b0, sq3_reg[0]} + {1'b0, sq3_reg[1]};
        over = behind_reg[2] || (|big3_reg) || sum[rit_pkg::SQ_W];
        err  = over ? '1 : sum[rit_pkg::ERR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                diff1_reg[l] <= pix[l] - cen[l] - off[l];
                mag2_reg[l]  <= adiff[l][rit_pkg::PIX_W-1:0];
                big2_reg[l]  <= |adiff[l][rit_pkg::DIFF_W-1:rit_pkg::PIX_W];
                sq3_reg[l]   <= rit_pkg::SQ_W'(mag2_reg[l]) * rit_pkg::SQ_W'(mag2_reg[l]);
            end
            big3_reg     <= big2_reg;
            behind_reg   <= {behind_reg[1:0], in_behind};
            index_reg[0] <= in_side.index;
            index_reg[1] <= index_reg[0];
            index_reg[2] <= index_reg[1];

            result_reg.index  <= index_reg[2];
            result_reg.behind <= behind_reg[2];
            result_reg.err    <= err;
            result_reg.inlier <= !over && (err <= limit);
        end
    end

    assign out_valid = vld_reg[3];
    assign result    = result_reg;

endmodule

FILE: rtl/rit_skid.sv
// Two-word output buffer between the pipeline and the result channel.
// Room is taken from the registered fill count. Uses rit_pkg::result_t.
module rit_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rit_pkg::result_t  in_word,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output rit_pkg::result_t  out_word
);

    localparam int DEPTH = 2;

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic              push;
    logic              pop;
    rit_pkg::result_t  slot_reg [DEPTH];

    assign room       = count_reg != 2'(DEPTH);
    assign out_valid  = count_reg != 2'd0;
    assign push       = room && in_valid;
    assign pop        = out_valid && out_ready;
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};
    assign out_word   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

FILE: rtl/reprojection_inlier_test.sv
// Top level of the reprojection inlier test: pose and intrinsics registers,
// transform, projection, error and output buffer. Uses rit_pkg and all rit_* modules.
//
// Usage:
//   s_* carries one 3D-2D correspondence per word; m_* returns one result word
//   per input word, in order. The cfg_* channel writes the pose, intrinsics and
//   squared limit by index; cfg_ready is always high and a write to an unused
//   index is dropped. Write configuration only with the pipeline empty.
//   Throughput: one word per cycle while the output buffer has room.
//   On its way to the result a word passes 2 transform stages,
//   4 projection setup stages, one stage per quotient bit of the 18-bit
//   divider, one offset stage, 4 error stages and the output buffer.
//   Reset: identity rotation, zero translation, f = 500, c = (320, 240),
//   limit 4.0 px^2, pipeline and output buffer empty.
//   Stall: results collect in a two-word output buffer; once it holds two
//   words s_tready drops and the whole pipeline holds until m_tready frees a
//   slot. Nothing is lost or repeated across a stall.
module reprojection_inlier_test (
    input  logic                              clk,
    input  logic                              rst_n,
    // point_index, point_x, point_y, point_z, image_u, image_v
    input  logic [rit_pkg::IN_W-1:0]          s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // result_index, error_sq
    output logic [rit_pkg::OUT_W-1:0]         m_tdata,
    // is_inlier, behind_camera
    output logic [rit_pkg::USER_W-1:0]        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rit_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rit_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int X_LO = rit_pkg::IDX_W;
    localparam int Y_LO = X_LO + rit_pkg::PT_W;
    localparam int Z_LO = Y_LO + rit_pkg::PT_W;
    localparam int U_LO = Z_LO + rit_pkg::PT_W;
    localparam int V_LO = U_LO + rit_pkg::PIX_W;

    logic [rit_pkg::ROW_W-1:0]             rot0_reg;
    logic [rit_pkg::ROW_W-1:0]             rot1_reg;
    logic [rit_pkg::ROW_W-1:0]             rot2_reg;
    logic [rit_pkg::TRV_W-1:0]             trans_reg;
    logic [rit_pkg::FPAIR_W-1:0]           focal_reg;
    logic [rit_pkg::FPAIR_W-1:0]           principal_reg;
    logic [rit_pkg::ERR_W-1:0]             limit_reg;

    logic                                  en;
    rit_pkg::side_t                        in_side;
    logic                                  tf_valid;
    rit_pkg::side_t                        tf_side;
    logic signed [rit_pkg::CAM_W-1:0]      cam_x;
    logic signed [rit_pkg::CAM_W-1:0]      cam_y;
    logic signed [rit_pkg::CAM_W-1:0]      cam_z;
    logic                                  pj_valid;
    rit_pkg::side_t                        pj_side;
    logic                                  pj_behind;
    logic signed [rit_pkg::OFF_W-1:0]      off_x;
    logic signed [rit_pkg::OFF_W-1:0]      off_y;
    logic                                  er_valid;
    rit_pkg::result_t                      er_word;
    rit_pkg::result_t                      out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg      <= rit_pkg::ROT0_RST;
            rot1_reg      <= rit_pkg::ROT1_RST;
            rot2_reg      <= rit_pkg::ROT2_RST;
            trans_reg     <= rit_pkg::TRANS_RST;
            focal_reg     <= rit_pkg::FOCAL_RST;
            principal_reg <= rit_pkg::PRINCIPAL_RST;
            limit_reg     <= rit_pkg::LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rit_pkg::CFG_ROT0:      rot0_reg      <= cfg_data[rit_pkg::ROW_W-1:0];
                rit_pkg::CFG_ROT1:      rot1_reg      <= cfg_data[rit_pkg::ROW_W-1:0];
                rit_pkg::CFG_ROT2:      rot2_reg      <= cfg_data[rit_pkg::ROW_W-1:0];
                rit_pkg::CFG_TRANS:     trans_reg     <= cfg_data[rit_pkg::TRV_W-1:0];
                rit_pkg::CFG_FOCAL:     focal_reg     <= cfg_data[rit_pkg::FPAIR_W-1:0];
                rit_pkg::CFG_PRINCIPAL: principal_reg <= cfg_data[rit_pkg::FPAIR_W-1:0];
                rit_pkg::CFG_LIMIT:     limit_reg     <= cfg_data[rit_pkg::ERR_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances while the output buffer has a free slot
    assign s_tready = en;

    assign in_side.index = s_tdata[rit_pkg::IDX_W-1:0];
    assign in_side.u     = s_tdata[U_LO +: rit_pkg::PIX_W];
    assign in_side.v     = s_tdata[V_LO +: rit_pkg::PIX_W];

    rit_transform u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_side   (in_side),
        .point_x   ($signed(s_tdata[X_LO +: rit_pkg::PT_W])),
        .point_y   ($signed(s_tdata[Y_LO +: rit_pkg::PT_W])),
        .point_z   ($signed(s_tdata[Z_LO +: rit_pkg::PT_W])),
        .rot0      (rot0_reg),
        .rot1      (rot1_reg),
        .rot2      (rot2_reg),
        .trans     (trans_reg),
        .out_valid (tf_valid),
        .out_side  (tf_side),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z)
    );

    rit_project u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (tf_valid),
        .in_side    (tf_side),
        .cam_x      (cam_x),
        .cam_y      (cam_y),
        .cam_z      (cam_z),
        .focal      (focal_reg),
        .out_valid  (pj_valid),
        .out_side   (pj_side),
        .out_behind (pj_behind),
        .off_x      (off_x),
        .off_y      (off_y)
    );

    rit_error u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pj_valid),
        .in_side   (pj_side),
        .in_behind (pj_behind),
        .off_x     (off_x),
        .off_y     (off_y),
        .principal (principal_reg),
        .limit     (limit_reg),
        .out_valid (er_valid),
        .result    (er_word)
    );

    rit_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (er_valid),
        .in_word   (er_word),
        .room      (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {out_word.err, out_word.index};
    assign m_tuser = {out_word.behind, out_word.inlier};

endmodule

FILE: rtl/rit_checker.sv
// Port-level checks for reprojection_inlier_test, attached by the bind below.
// Uses rit_pkg for field widths.
module rit_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic [rit_pkg::OUT_W-1:0]      m_tdata,
    input logic [rit_pkg::USER_W-1:0]     m_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    logic [rit_pkg::ERR_W-1:0] err;

    assign err = m_tdata[rit_pkg::OUT_W-1:rit_pkg::IDX_W];

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a point behind the camera is never an inlier and reports a saturated error
    a_behind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (err == '1))
        else $error("behind-camera result not flagged as saturated outlier");

    // a saturated error is never an inlier
    a_inlier: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> err != '1)
        else $error("inlier with saturated error");

    // pipeline comes out of reset empty
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind reprojection_inlier_test rit_checker u_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for reprojection_inlier_test: streams 3D-2D correspondences,
// predicts each verdict with an in-house fixed-point pinhole model and checks every result.
// Depends on rit_pkg and the reprojection_inlier_test RTL.
`timescale 1ns / 1ps

module testbench;
    import rit_pkg::*;

    localparam int LATENCY     = 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // one input word, index in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] u;
        logic [PT_W-1:0]  z;
        logic [PT_W-1:0]  y;
        logic [PT_W-1:0]  x;
        logic [IDX_W-1:0] index;
    } point_word_t;

    typedef struct {
        bit     behind;
        longint ue;
        longint ve;
    } pixel_t;

    class inlier_scoreboard;
        logic [ROW_W-1:0]   rot [3];
        logic [TRV_W-1:0]   trans;
        logic [FPAIR_W-1:0] focal;
        logic [FPAIR_W-1:0] principal;
        logic [ERR_W-1:0]   limit;
        result_t            expected_verdicts [$];
        int                 errors;

        function new();
            rot[0]    = ROT0_RST;
            rot[1]    = ROT1_RST;
            rot[2]    = ROT2_RST;
            trans     = TRANS_RST;
            focal     = FOCAL_RST;
            principal = PRINCIPAL_RST;
            limit     = LIMIT_RST;
            errors    = 0;
        endfunction

        // drop bits above each register's width; unused index is ignored
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROT0:      rot[0]    = data[ROW_W-1:0];
                CFG_ROT1:      rot[1]    = data[ROW_W-1:0];
                CFG_ROT2:      rot[2]    = data[ROW_W-1:0];
                CFG_TRANS:     trans     = data[TRV_W-1:0];
                CFG_FOCAL:     focal     = data[FPAIR_W-1:0];
                CFG_PRINCIPAL: principal = data[FPAIR_W-1:0];
                CFG_LIMIT:     limit     = data[ERR_W-1:0];
                default:       ;
            endcase
        endfunction

        // round(f * num / den) to nearest, ties away from zero, den > 0
        function longint scaled_offset(longint f, longint num, longint den);
            longint            prod;
            longint unsigned   mag;
            longint unsigned   d;
            longint unsigned   q;
            prod = f * num;
            mag  = (prod < 0) ? -prod : prod;
            d    = den;
            q    = (2 * mag + d) / (2 * d);
            return (prod < 0) ? -longint'(q) : longint'(q);
        endfunction

        function pixel_t project_point(logic [PT_W-1:0] px, logic [PT_W-1:0] py,
                                       logic [PT_W-1:0] pz);
            longint                p [3];
            longint                cam [3];
            logic signed [ROT_W-1:0] r_e;
            logic signed [TR_W-1:0]  t_e;
            pixel_t                pix;
            p[0] = longint'($signed(px));
            p[1] = longint'($signed(py));
            p[2] = longint'($signed(pz));
            for (int r = 0; r < 3; r++)
            begin
                t_e    = trans[TR_W*r +: TR_W];
                cam[r] = longint'(t_e) * (longint'(1) << TR_SHIFT);
                for (int c = 0; c < 3; c++)
                begin
                    r_e    = rot[r][ROT_W*c +: ROT_W];
                    cam[r] = cam[r] + longint'(r_e) * p[c];
                end
            end
            pix.behind = (cam[2] <= 0);
            pix.ue     = 0;
            pix.ve     = 0;
            if (!pix.behind)
            begin
                pix.ue = longint'(principal[FOC_W-1:0])
                       + scaled_offset(longint'(focal[FOC_W-1:0]), cam[0], cam[2]);
                pix.ve = longint'(principal[FOC_W +: FOC_W])
                       + scaled_offset(longint'(focal[FOC_W +: FOC_W]), cam[1], cam[2]);
            end
            return pix;
        endfunction

        function result_t score_point(point_word_t w);
            result_t         res;
            pixel_t          pix;
            longint          du;
            longint          dv;
            longint unsigned adu;
            longint unsigned adv;
            longint unsigned sum;
            bit              over;
            pix        = project_point(w.x, w.y, w.z);
            res.index  = w.index;
            res.behind = pix.behind;
            res.err    = '1;
            over       = pix.behind;
            if (!pix.behind)
            begin
                du  = longint'(w.u) - pix.ue;
                dv  = longint'(w.v) - pix.ve;
                adu = (du < 0) ? -du : du;
                adv = (dv < 0) ? -dv : dv;
                if (adu >= 65536 || adv >= 65536)
                begin
                    over = 1'b1;
                end
                else
                begin
                    sum = adu * adu + adv * adv;
                    if (sum > 64'hFFFF_FFFF)
                        over = 1'b1;
                    else
                        res.err = sum[ERR_W-1:0];
                end
            end
            res.inlier = !pix.behind && !over && (res.err <= limit);
            return res;
        endfunction

        function void note_point(point_word_t w);
            expected_verdicts = {expected_verdicts, score_point(w)};
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_verdict(result_t got);
            result_t want;
            if (expected_verdicts.size() == 0)
            begin
                report($sformatf("result for index %h with no word pending", got.index));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.index !== want.index)
                report($sformatf("index got %h want %h", got.index, want.index));
            if (got.inlier !== want.inlier)
                report($sformatf("index %h inlier got %b want %b",
                                 want.index, got.inlier, want.inlier));
            if (got.behind !== want.behind)
                report($sformatf("index %h behind got %b want %b",
                                 want.index, got.behind, want.behind));
            if (got.err !== want.err)
                report($sformatf("index %h error_sq got %h want %h",
                                 want.index, got.err, want.err));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic [USER_W-1:0]     m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    inlier_scoreboard sb;
    bit               calm = 1'b0;
    int unsigned      cycle_count = 0;

    reprojection_inlier_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: stall at random except during the calm stretch
    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_verdict(result_t'({m_tdata[IDX_W-1:0], m_tuser[0], m_tuser[1],
                                        m_tdata[IDX_W +: ERR_W]}));
    end

    task send_point(point_word_t w);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_point(w);
    endtask

    task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // junk above each register's width must be ignored
    task configure(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1, logic [ROW_W-1:0] r2,
                   logic [TRV_W-1:0] t, logic [FPAIR_W-1:0] f, logic [FPAIR_W-1:0] c,
                   logic [ERR_W-1:0] lim);
        write_register(CFG_ROT0, {16'($urandom), r0});
        write_register(CFG_ROT1, {16'($urandom), r1});
        write_register(CFG_ROT2, {16'($urandom), r2});
        write_register(CFG_TRANS, {1'($urandom), t});
        write_register(CFG_FOCAL, {32'($urandom), f});
        write_register(CFG_PRINCIPAL, {32'($urandom), c});
        write_register(CFG_LIMIT, {32'($urandom), lim});
    endtask

    task wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    function automatic point_word_t make_point(logic [IDX_W-1:0] idx, int x, int y, int z,
                                               int u, int v);
        point_word_t w;
        w.index = idx;
        w.x     = PT_W'(x);
        w.y     = PT_W'(y);
        w.z     = PT_W'(z);
        w.u     = PIX_W'(u);
        w.v     = PIX_W'(v);
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] near_row(int r);
        logic [ROW_W-1:0] row;
        for (int c = 0; c < 3; c++)
            row[ROT_W*c +: ROT_W] = (c == r) ? ROT_W'(16384 - int'($urandom_range(0, 600)))
                                             : ROT_W'(int'($urandom_range(0, 2400)) - 1200);
        return row;
    endfunction

    // mostly consistent correspondences with small pixel noise, the rest raw noise
    task send_random_points(int n);
        point_word_t w;
        pixel_t      pix;
        int          zr;
        int          nz;
        longint      pu;
        longint      pv;
        for (int i = 0; i < n; i++)
        begin
            w.index = IDX_W'($urandom);
            if ($urandom_range(0, 99) < 70)
            begin
                zr  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8388607))
                                                  : int'($urandom_range(64, 65536));
                w.z = PT_W'(zr);
                w.x = PT_W'(int'($urandom_range(0, zr)) - zr / 2);
                w.y = PT_W'(int'($urandom_range(0, zr)) - zr / 2);
                pix = sb.project_point(w.x, w.y, w.z);
                if (pix.behind)
                begin
                    w.u = PIX_W'($urandom);
                    w.v = PIX_W'($urandom);
                end
                else
                begin
                    nz = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4096)) - 2048
                                                     : int'($urandom_range(0, 80)) - 40;
                    pu = pix.ue + nz;
                    nz = int'($urandom_range(0, 80)) - 40;
                    pv = pix.ve + nz;
                    if (pu < 0) pu = 0;
                    if (pu > 65535) pu = 65535;
                    if (pv < 0) pv = 0;
                    if (pv > 65535) pv = 65535;
                    w.u = pu[PIX_W-1:0];
                    w.v = pv[PIX_W-1:0];
                end
            end
            else
            begin
                w.x = PT_W'($urandom);
                w.y = PT_W'($urandom);
                w.z = PT_W'($urandom);
                w.u = PIX_W'($urandom);
                w.v = PIX_W'($urandom);
            end
            send_point(w);
        end
    endtask

    initial
    begin : stimulus
        int               cx;
        int               cy;
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r2;
        logic [TRV_W-1:0] t;
        logic [FPAIR_W-1:0] f;
        logic [ERR_W-1:0] lim;
        sb = new();
        cx = int'(PRINCIPAL_RST[FOC_W-1:0]);
        cy = int'(PRINCIPAL_RST[FOC_W +: FOC_W]);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset pose: identity, f = 500, c = (320, 240), limit 4 px^2
        send_point(make_point(16'h0000, 0, 0, 0, cx, cy));                // zero depth
        send_point(make_point(16'h0001, 0, 0, -256, cx, cy));             // behind camera
        send_point(make_point(16'h0002, 0, 0, 1, cx, cy));                // tiniest depth
        send_point(make_point(16'h0003, 0, 0, 256, cx, cy));
        send_point(make_point(16'h0004, 0, 0, 256, cx + 32, cy));         // exactly at limit
        send_point(make_point(16'h0005, 0, 0, 256, cx + 33, cy));         // just past limit
        send_point(make_point(16'h0006, 0, 0, 256, cx, cy - 32));
        send_point(make_point(16'h0007, 1, 0, 16000, cx + 1, cy));        // half-pixel tie
        send_point(make_point(16'h0008, -1, 0, 16000, cx - 1, cy));       // negative tie
        send_point(make_point(16'h0009, 0, -1, 16000, cx, cy - 1));
        send_point(make_point(16'h000a, 0, 0, 256, 16'hFFFF, cy));        // large but exact
        send_point(make_point(16'h000b, 0, 0, 256, 16'hFFFF, 16'hFFFF));  // sum past 32 bits
        send_point(make_point(16'h000c, 8388607, 0, 1, 0, 0));            // offset overflow
        send_point(make_point(16'h000d, -8388608, -8388608, 8388607, 0, 0));
        send_point(make_point(16'h000e, 8388607, 8388607, 8388607, 16'hFFFF, 16'hFFFF));
        send_point(make_point(16'h000f, 0, 0, -8388608, 0, 0));
        send_point(make_point(16'h0010, 0, 0, 8388607, 0, 0));
        send_point(make_point(16'hFFFF, 256, 256, 256, cx + 8000, cy + 8000));
        send_point(make_point(16'h8000, -256, 128, 512, cx - 4000, cy + 2000));
        send_random_points(150);
        wait_drained();

        // everything zero: every depth collapses to zero
        configure('0, '0, '0, '0, '0, '0, '0);
        send_random_points(60);
        wait_drained();

        // everything at its maximum, then a write to the unused index
        configure('1, '1, '1, '1, '1, '1, '1);
        write_register(CFG_UNUSED, {$urandom, $urandom});
        send_random_points(60);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 5)
            begin
                r0 = ROW_W'({$urandom, $urandom});
                r1 = ROW_W'({$urandom, $urandom});
                r2 = ROW_W'({$urandom, $urandom});
                t  = TRV_W'({$urandom, $urandom});
            end
            else
            begin
                r0 = near_row(0);
                r1 = near_row(1);
                r2 = near_row(2);
                t  = {TR_W'($urandom_range(0, 262144)),
                      TR_W'(int'($urandom_range(0, 131072)) - 65536),
                      TR_W'(int'($urandom_range(0, 131072)) - 65536)};
            end
            f = {FOC_W'($urandom_range(1600, 16000)), FOC_W'($urandom_range(1600, 16000))};
            if (ph == 4)
                lim = '0;
            else if (ph == 6)
                lim = '1;
            else if ($urandom_range(0, 3) == 0)
                lim = ERR_W'($urandom);
            else
                lim = ERR_W'($urandom_range(0, 16384));
            configure(r0, r1, r2, t, f, FPAIR_W'($urandom), lim);
            calm = (ph == 2);
            send_random_points((ph == 2) ? 300 : 150);
            wait_drained();
            calm = 1'b0;
        end

        if (sb.errors == 0 && sb.expected_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rit_pkg.sv
rtl/rit_transform.sv
rtl/rit_div_step.sv
rtl/rit_project.sv
rtl/rit_error.sv
rtl/rit_skid.sv
rtl/reprojection_inlier_test.sv
rtl/rit_checker.sv
tb/testbench.sv
